// ----- hw/rtl/tpc_pkg.sv -----
// Shared types, constants and per-axis helper functions of the two-point calibration block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tpc_pkg;

  localparam int FIELD_W    = 16;
  localparam int RAW_W      = 12;
  localparam int PIX_W      = 8;
  localparam int NUM_W      = RAW_W + 8;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;
  localparam int IN_W       = 8 * FIELD_W;
  localparam int OUT_W      = 4 * FIELD_W;

  localparam logic [FIELD_W-1:0] RAW_LIMIT   = 16'h1000;
  localparam logic [FIELD_W-1:0] PIX_X_LIMIT = 16'd256;
  localparam logic [FIELD_W-1:0] PIX_Y_LIMIT = 16'd192;
  localparam logic [NUM_W-1:0]   POS_MAX     = 20'h07FFF;
  localparam logic [NUM_W-1:0]   NEG_MAX     = 20'h08000;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [PIX_W-1:0]   rem;
    logic [PIX_W-1:0]   den;
    logic               neg;
    logic [RAW_W:0]     raw_sum;
    logic [PIX_W:0]     pix_sum;
  } axis_t;

  typedef struct packed {
    logic  valid;
    logic  ok;
    axis_t x;
    axis_t y;
  } stage_t;

  function automatic axis_t axis_prep(input logic [FIELD_W-1:0] raw1,
                                      input logic [FIELD_W-1:0] raw2,
                                      input logic [FIELD_W-1:0] pix1,
                                      input logic [FIELD_W-1:0] pix2);
    axis_t          a;
    logic [RAW_W:0] rw;
    logic [RAW_W:0] rw_neg;
    logic [PIX_W:0] pw;
    logic [PIX_W:0] pw_neg;
    rw     = {1'b0, raw1[RAW_W-1:0]} - {1'b0, raw2[RAW_W-1:0]};
    rw_neg = {(RAW_W+1){1'b0}} - rw;
    pw     = {1'b0, pix1[PIX_W-1:0]} - {1'b0, pix2[PIX_W-1:0]};
    pw_neg = {(PIX_W+1){1'b0}} - pw;
    a.num     = {(rw[RAW_W] ? rw_neg[RAW_W-1:0] : rw[RAW_W-1:0]), 8'h00};
    a.den     = pw[PIX_W] ? pw_neg[PIX_W-1:0] : pw[PIX_W-1:0];
    a.rem     = '0;
    a.neg     = rw[RAW_W] ^ pw[PIX_W];
    a.raw_sum = {1'b0, raw1[RAW_W-1:0]} + {1'b0, raw2[RAW_W-1:0]};
    a.pix_sum = {1'b0, pix1[PIX_W-1:0]} + {1'b0, pix2[PIX_W-1:0]};
    return a;
  endfunction

  // Restoring division, one quotient bit per step, quotient shifted into num.
  function automatic axis_t div_steps(input axis_t a_in);
    axis_t        a;
    logic [PIX_W:0] trial;
    a = a_in;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {a.rem, a.num[NUM_W-1]};
      if (trial >= {1'b0, a.den}) begin
        trial = trial - {1'b0, a.den};
        a.num = {a.num[NUM_W-2:0], 1'b1};
      end else begin
        a.num = {a.num[NUM_W-2:0], 1'b0};
      end
      a.rem = trial[PIX_W-1:0];
    end
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/touch_two_point_calibration.sv -----
// Top level of the two-point touch calibration block: stream ports and pipeline stages.
// Depends on tpc_pkg, tpc_prep, tpc_div_stage and tpc_finish.
//
// One input item carries two calibration points (raw panel reading and screen pixel
// each) on s_tdata; one result item per input leaves on m_tdata, with the failure flag
// on m_tuser. When m_tuser is high all of m_tdata is zero.
// The block is a fixed pipeline of eight register stages: an input check stage, five
// divider stages of four quotient bits each, a sign and range stage, and a stage that
// forms the offset into the output register. One item can be accepted in every cycle
// while the output register is empty or being taken.
// All stages advance together whenever the output register is empty or being taken,
// so s_tready follows !m_tvalid || m_tready; while the receiver stalls, every stage
// holds and no item is lost or repeated.
// Synchronous reset empties the pipeline; no result is pending afterwards.
`default_nettype none
module touch_two_point_calibration (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // raw_x_first, raw_y_first, pix_x_first, pix_y_first,
  // raw_x_second, raw_y_second, pix_x_second, pix_y_second
  input  wire logic [tpc_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // x_offset, y_offset, x_dot_size, y_dot_size
  output logic [tpc_pkg::OUT_W-1:0]      m_tdata,
  // failed
  output logic                           m_tuser
);
  import tpc_pkg::*;

  logic   en;
  stage_t pipe [0:DIV_STAGES];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tpc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .out      (pipe[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tpc_div_stage u_div (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .in  (pipe[g]),
      .out (pipe[g+1])
    );
  end

  tpc_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in         (pipe[DIV_STAGES]),
    .out_valid  (m_tvalid),
    .out_data   (m_tdata),
    .out_failed (m_tuser)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/tpc_prep.sv -----
// Input stage: range and distinctness checks, signed differences split into sign and magnitude.
// Depends on tpc_pkg.
`default_nettype none
module tpc_prep (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [tpc_pkg::IN_W-1:0] in_data,
  output tpc_pkg::stage_t              out
);
  import tpc_pkg::*;

  logic [FIELD_W-1:0] rx1, ry1, px1, py1, rx2, ry2, px2, py2;
  logic               in_ok;

  assign rx1 = in_data[0*FIELD_W +: FIELD_W];
  assign ry1 = in_data[1*FIELD_W +: FIELD_W];
  assign px1 = in_data[2*FIELD_W +: FIELD_W];
  assign py1 = in_data[3*FIELD_W +: FIELD_W];
  assign rx2 = in_data[4*FIELD_W +: FIELD_W];
  assign ry2 = in_data[5*FIELD_W +: FIELD_W];
  assign px2 = in_data[6*FIELD_W +: FIELD_W];
  assign py2 = in_data[7*FIELD_W +: FIELD_W];

  assign in_ok = (rx1 < RAW_LIMIT) && (ry1 < RAW_LIMIT) && (rx2 < RAW_LIMIT) &&
                 (ry2 < RAW_LIMIT) && (px1 < PIX_X_LIMIT) && (px2 < PIX_X_LIMIT) &&
                 (py1 < PIX_Y_LIMIT) && (py2 < PIX_Y_LIMIT) && (px1 != px2) &&
                 (py1 != py2) && (rx1 != rx2) && (ry1 != ry2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= in_valid;
    end
    if (en) begin
      out.ok <= in_ok;
      out.x  <= axis_prep(rx1, rx2, px1, px2);
      out.y  <= axis_prep(ry1, ry2, py1, py2);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tpc_div_stage.sv -----
// One register stage of the pipelined divider, four quotient bits for both axes.
// Depends on tpc_pkg.
`default_nettype none
module tpc_div_stage (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire tpc_pkg::stage_t in,
  output tpc_pkg::stage_t out
);
  import tpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= in.valid;
    end
    if (en) begin
      out.ok <= in.ok;
      out.x  <= div_steps(in.x);
      out.y  <= div_steps(in.y);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tpc_finish.sv -----
// Final two stages: signed dot size with overflow check, then offset and the output register.
// Depends on tpc_pkg.
`default_nettype none
module tpc_finish (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire tpc_pkg::stage_t          in,
  output logic                          out_valid,
  output logic [tpc_pkg::OUT_W-1:0]     out_data,
  output logic                          out_failed
);
  import tpc_pkg::*;

  logic                      valid_a;
  logic                      ok_a;
  logic signed [FIELD_W-1:0] xdot_a, ydot_a;
  logic [RAW_W:0]            xraw_a, yraw_a;
  logic [PIX_W:0]            xpix_a, ypix_a;

  logic                      xover, yover;
  logic [FIELD_W-1:0]        xq, yq;

  logic signed [25:0]        xprod, yprod;
  logic signed [26:0]        xv, yv;

  assign xover = in.x.neg ? (in.x.num > NEG_MAX) : (in.x.num > POS_MAX);
  assign yover = in.y.neg ? (in.y.num > NEG_MAX) : (in.y.num > POS_MAX);
  assign xq    = in.x.neg ? (16'd0 - in.x.num[FIELD_W-1:0]) : in.x.num[FIELD_W-1:0];
  assign yq    = in.y.neg ? (16'd0 - in.y.num[FIELD_W-1:0]) : in.y.num[FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in.valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_a   <= in.ok && !xover && !yover;
      xdot_a <= xq;
      ydot_a <= yq;
      xraw_a <= in.x.raw_sum;
      yraw_a <= in.y.raw_sum;
      xpix_a <= in.x.pix_sum;
      ypix_a <= in.y.pix_sum;
    end
  end

  assign xprod = $signed({16'd0, xpix_a}) * $signed({{10{xdot_a[FIELD_W-1]}}, xdot_a});
  assign yprod = $signed({16'd0, ypix_a}) * $signed({{10{ydot_a[FIELD_W-1]}}, ydot_a});
  assign xv    = $signed({6'd0, xraw_a, 8'h00}) - $signed({xprod[25], xprod});
  assign yv    = $signed({6'd0, yraw_a, 8'h00}) - $signed({yprod[25], yprod});

  always_ff @(posedge clk) begin
    if (en) begin
      out_failed <= !ok_a;
      if (ok_a) begin
        out_data <= {ydot_a, xdot_a, yv[22:7], xv[22:7]};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tpc_checker.sv -----
// Port-level checks of the calibration block, attached to the top level by bind.
// Depends on tpc_pkg and touch_two_point_calibration.
`default_nettype none
module tpc_checker (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tready,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [tpc_pkg::OUT_W-1:0] m_tdata,
  input wire logic                     m_tuser
);
  import tpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("failed result carries non-zero data");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow the output side");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind touch_two_point_calibration tpc_checker u_tpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
